@@ rtl/u1_plaquette_gauge_force_core_defines.svh @@
// assertion macros for the u1 plaquette gauge force core checker
// no dependencies; expects clock and reset in the scope of each use
`ifndef U1_PLAQUETTE_GAUGE_FORCE_CORE_DEFINES_SVH
`define U1_PLAQUETTE_GAUGE_FORCE_CORE_DEFINES_SVH

// antecedent in this cycle implies consequent in the next cycle
`define U1PG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("u1pg: next-cycle check failed");

// antecedent implies consequent in the same cycle
`define U1PG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("u1pg: same-cycle check failed");

`endif

@@ rtl/u1pg_pkg.sv @@
// shared types, constants and helper functions of the u1 plaquette gauge force core
// no dependencies
package u1pg_pkg;

   // lattice geometry
   localparam int LATTICE_X  = 16;
   localparam int LATTICE_Y  = 16;
   localparam int XW         = $clog2(LATTICE_X);
   localparam int YW         = $clog2(LATTICE_Y);
   localparam int LINK_DEPTH = LATTICE_X * LATTICE_Y * 2;
   localparam int LINK_AW    = $clog2(LINK_DEPTH);

   // port field widths
   localparam int SITE_W    = 4;
   localparam int LINK_W    = 16;
   localparam int WORD_W    = 2 * LINK_W;
   localparam int BETA_W    = 16;
   localparam int FORCE_W   = 32;

   // datapath widths: components stay within +-8 in q.15, diff within +-16
   localparam int CW        = 24;
   localparam int BW        = LINK_W + 1;
   localparam int PW        = CW + BW;
   localparam int ACCW      = PW + 1;
   localparam int LINK_FRAC = 15;
   localparam int FORCE_SH  = 7;

   localparam logic signed [ACCW-1:0] HALF_LINK  = ACCW'(2 ** (LINK_FRAC - 1));
   localparam logic signed [ACCW-1:0] HALF_FORCE = ACCW'(2 ** (FORCE_SH - 1));

   localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(256);

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // link directions
   localparam logic DIR_X = 1'b0;
   localparam logic DIR_Y = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_LOAD,
      S_RR,
      S_II,
      S_RI,
      S_IR,
      S_RND,
      S_DIFF,
      S_BETA,
      S_DONE
   } seq_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_T,
      OP_RR,
      OP_II_SUB,
      OP_RI,
      OP_IR_ADD,
      OP_ROUND_T,
      OP_DIFF_FIRST,
      OP_DIFF_SUB,
      OP_BETA
   } mac_op_type;

   typedef struct packed {
      mac_op_type op;
      logic       conj;
   } mac_ctrl_type;

   function automatic logic [XW-1:0] reduce_x(input logic [SITE_W-1:0] v);
      int t;
      t = int'(v);
      if (t >= LATTICE_X) t = t - LATTICE_X;
      return XW'(t);
   endfunction

   function automatic logic [YW-1:0] reduce_y(input logic [SITE_W-1:0] v);
      int t;
      t = int'(v);
      if (t >= LATTICE_Y) t = t - LATTICE_Y;
      return YW'(t);
   endfunction

   function automatic logic [XW-1:0] inc_x(input logic [XW-1:0] v);
      return (v == XW'(LATTICE_X - 1)) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [XW-1:0] dec_x(input logic [XW-1:0] v);
      return (v == '0) ? XW'(LATTICE_X - 1) : v - 1'b1;
   endfunction

   function automatic logic [YW-1:0] inc_y(input logic [YW-1:0] v);
      return (v == YW'(LATTICE_Y - 1)) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [YW-1:0] dec_y(input logic [YW-1:0] v);
      return (v == '0) ? YW'(LATTICE_Y - 1) : v - 1'b1;
   endfunction

   // site-major, y next, direction last
   function automatic logic [LINK_AW-1:0] link_addr(input logic [XW-1:0] x,
                                                    input logic [YW-1:0] y,
                                                    input logic          dir);
      return LINK_AW'((int'(x) * LATTICE_Y + int'(y)) * 2 + int'(dir));
   endfunction

endpackage

@@ rtl/u1pg_link_ram.sv @@
// link store: one write port, one registered read port
// depends on u1pg_pkg
module u1pg_link_ram
   import u1pg_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [LINK_AW-1:0] wr_addr,
   input  logic [WORD_W-1:0]  wr_data,
   input  logic [LINK_AW-1:0] rd_addr,
   output logic [WORD_W-1:0]  rd_data
);

   logic [WORD_W-1:0] mem [LINK_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/u1pg_mac_unit.sv @@
// shared complex multiply-accumulate unit with running plaquette and difference
// depends on u1pg_pkg
module u1pg_mac_unit
   import u1pg_pkg::*;
(
   input  logic                      clock,
   input  mac_ctrl_type              ctrl,
   input  logic [WORD_W-1:0]         link_word,
   input  logic [BETA_W-1:0]         beta,
   output logic signed [FORCE_W-1:0] force_value
);

   logic signed [CW-1:0]   t_re_ff, t_re_in;
   logic signed [CW-1:0]   t_im_ff, t_im_in;
   logic signed [CW-1:0]   re_hold_ff, re_hold_in;
   logic signed [CW-1:0]   diff_ff, diff_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;

   logic signed [LINK_W-1:0] l_re, l_im;
   logic signed [BW-1:0]     b_re, b_im;
   logic signed [CW-1:0]     ma;
   logic signed [BW-1:0]     mb;
   logic signed [PW-1:0]     prod;
   logic signed [ACCW-1:0]   prod_ext;
   logic signed [ACCW-1:0]   rnd_sum, rnd_sh;
   logic signed [ACCW-1:0]   f_sum, f_sh;
   logic signed [CW-1:0]     rnd15;

   assign l_re = link_word[WORD_W-1:LINK_W];
   assign l_im = link_word[LINK_W-1:0];
   assign b_re = {l_re[LINK_W-1], l_re};
   assign b_im = ctrl.conj ? -{l_im[LINK_W-1], l_im} : {l_im[LINK_W-1], l_im};

   // operand select for the one multiplier
   always_comb begin
      unique case (ctrl.op)
         OP_RR:     begin ma = t_re_ff; mb = b_re; end
         OP_II_SUB: begin ma = t_im_ff; mb = b_im; end
         OP_RI:     begin ma = t_re_ff; mb = b_im; end
         OP_IR_ADD: begin ma = t_im_ff; mb = b_re; end
         OP_BETA:   begin ma = diff_ff; mb = signed'({1'b0, beta}); end
         default:   begin ma = t_re_ff; mb = b_re; end
      endcase
   end

   assign prod     = ma * mb;
   assign prod_ext = {prod[PW-1], prod};

   // round half up back to 15 fraction bits
   assign rnd_sum = acc_ff + HALF_LINK;
   assign rnd_sh  = rnd_sum >>> LINK_FRAC;
   assign rnd15   = rnd_sh[CW-1:0];

   // q.15 times q8.8 down to q.16
   assign f_sum       = acc_ff + HALF_FORCE;
   assign f_sh        = f_sum >>> FORCE_SH;
   assign force_value = f_sh[FORCE_W-1:0];

   always_comb begin
      acc_in     = acc_ff;
      t_re_in    = t_re_ff;
      t_im_in    = t_im_ff;
      re_hold_in = re_hold_ff;
      diff_in    = diff_ff;
      unique case (ctrl.op)
         OP_LOAD_T: begin
            t_re_in = {{(CW-LINK_W){l_re[LINK_W-1]}}, l_re};
            t_im_in = {{(CW-LINK_W){l_im[LINK_W-1]}}, l_im};
         end
         OP_RR:     acc_in = prod_ext;
         OP_II_SUB: acc_in = acc_ff - prod_ext;
         OP_RI: begin
            re_hold_in = rnd15;
            acc_in     = prod_ext;
         end
         OP_IR_ADD: acc_in = acc_ff + prod_ext;
         OP_ROUND_T: begin
            t_re_in = re_hold_ff;
            t_im_in = rnd15;
         end
         OP_DIFF_FIRST: diff_in = t_im_ff;
         OP_DIFF_SUB:   diff_in = diff_ff - t_im_ff;
         OP_BETA:       acc_in  = prod_ext;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      t_re_ff    <= t_re_in;
      t_im_ff    <= t_im_in;
      re_hold_ff <= re_hold_in;
      diff_ff    <= diff_in;
   end

endmodule

@@ rtl/u1_plaquette_gauge_force_core.sv @@
// top level of the u1 plaquette gauge force core: command decode, sequencer, csr
// depends on u1pg_pkg, u1pg_link_ram and u1pg_mac_unit
//
//   channel   direction  handshake             payload
//   command   in         start / busy          req_command, req_site_x, req_site_y,
//                                              req_direction, req_link_real, req_link_imag
//   result    out        rsp_valid strobe      rsp_force_value
//   csr       in         csr_wr_en             csr_wr_data (coupling beta, q8.8)
//
// a write word goes straight into the link store and busy stays low
// a read word holds busy until its result strobes, in the cycle in which busy
// falls; no new word is taken while busy is high; the single shared multiplier
// walks 2 plaquettes x 3 complex products x 4 partial products, plus link fetches
// and one beta scaling
// reset is synchronous, active high, and sets beta to 1.0; link contents are kept
// the result is shown for exactly one cycle and cannot be held off
module u1_plaquette_gauge_force_core
   import u1pg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_command,
   input  logic [SITE_W-1:0]          req_site_x,
   input  logic [SITE_W-1:0]          req_site_y,
   input  logic                       req_direction,
   input  logic signed [LINK_W-1:0]   req_link_real,
   input  logic signed [LINK_W-1:0]   req_link_imag,
   output logic                       rsp_valid,
   output logic signed [FORCE_W-1:0]  rsp_force_value,
   input  logic                       csr_wr_en,
   input  logic [BETA_W-1:0]          csr_wr_data
);

   seq_state_type state_ff, state_in;

   logic [BETA_W-1:0]         beta_ff;
   logic [XW-1:0]             x_ff, x_in;
   logic [YW-1:0]             y_ff, y_in;
   logic                      dir_ff, dir_in;
   // bit 2 picks the plaquette, bits 1:0 the link around it
   logic [2:0]                link_cnt_ff, link_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [FORCE_W-1:0] rsp_force_ff, rsp_force_in;

   logic                      accept;
   logic                      wr_en;
   logic [LINK_AW-1:0]        wr_addr;
   logic [LINK_AW-1:0]        rd_addr;
   logic [WORD_W-1:0]         rd_data;
   logic [XW-1:0]             px, lx;
   logic [YW-1:0]             py, ly;
   logic                      ldir;
   mac_ctrl_type              mac_ctrl;
   logic signed [FORCE_W-1:0] mac_force;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // link writes go straight into the store
   assign wr_en   = accept && (req_command == CMD_WRITE);
   assign wr_addr = link_addr(reduce_x(req_site_x), reduce_y(req_site_y), req_direction);

   // plaquette corner: the first one is added, the second subtracted
   always_comb begin
      px = x_ff;
      py = y_ff;
      if (dir_ff == DIR_X) begin
         if (link_cnt_ff[2]) py = dec_y(y_ff);
      end else begin
         if (!link_cnt_ff[2]) px = dec_x(x_ff);
      end
   end

   // links around the plaquette: forward x, forward y at x+1, back x at y+1, back y
   always_comb begin
      unique case (link_cnt_ff[1:0])
         2'd0:    begin lx = px;        ly = py;        ldir = DIR_X; end
         2'd1:    begin lx = inc_x(px); ly = py;        ldir = DIR_Y; end
         2'd2:    begin lx = px;        ly = inc_y(py); ldir = DIR_X; end
         default: begin lx = px;        ly = py;        ldir = DIR_Y; end
      endcase
   end

   assign rd_addr = link_addr(lx, ly, ldir);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept && (req_command == CMD_READ)) state_in = S_FETCH;
         S_FETCH: state_in = (link_cnt_ff[1:0] == 2'd0) ? S_LOAD : S_RR;
         S_LOAD:  state_in = S_FETCH;
         S_RR:    state_in = S_II;
         S_II:    state_in = S_RI;
         S_RI:    state_in = S_IR;
         S_IR:    state_in = S_RND;
         S_RND:   state_in = (link_cnt_ff[1:0] == 2'd3) ? S_DIFF : S_FETCH;
         // counter has already stepped past the last link here
         S_DIFF:  state_in = link_cnt_ff[2] ? S_FETCH : S_BETA;
         S_BETA:  state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      x_in          = x_ff;
      y_in          = y_ff;
      dir_in        = dir_ff;
      link_cnt_in   = link_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_force_in  = rsp_force_ff;
      mac_ctrl.op   = OP_NONE;
      mac_ctrl.conj = link_cnt_ff[1];
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_command == CMD_READ)) begin
               x_in        = reduce_x(req_site_x);
               y_in        = reduce_y(req_site_y);
               dir_in      = req_direction;
               link_cnt_in = '0;
            end
         end
         S_LOAD: begin
            mac_ctrl.op = OP_LOAD_T;
            link_cnt_in = link_cnt_ff + 1'b1;
         end
         S_RR: mac_ctrl.op = OP_RR;
         S_II: mac_ctrl.op = OP_II_SUB;
         S_RI: mac_ctrl.op = OP_RI;
         S_IR: mac_ctrl.op = OP_IR_ADD;
         S_RND: begin
            mac_ctrl.op = OP_ROUND_T;
            link_cnt_in = link_cnt_ff + 1'b1;
         end
         S_DIFF: mac_ctrl.op = link_cnt_ff[2] ? OP_DIFF_FIRST : OP_DIFF_SUB;
         S_BETA: mac_ctrl.op = OP_BETA;
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_force_in = mac_force;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         beta_ff      <= BETA_RESET;
         link_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         link_cnt_ff  <= link_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            beta_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      dir_ff       <= dir_in;
      rsp_force_ff <= rsp_force_in;
   end

   u1pg_link_ram u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_link_real, req_link_imag}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   u1pg_mac_unit u_mac_unit (
      .clock       (clock),
      .ctrl        (mac_ctrl),
      .link_word   (rd_data),
      .beta        (beta_ff),
      .force_value (mac_force)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_force_value = rsp_force_ff;

endmodule

@@ rtl/u1pg_core_checker.sv @@
// port-level checks of the u1 plaquette gauge force core, bound to the top level
// depends on u1_plaquette_gauge_force_core_defines.svh
`include "u1_plaquette_gauge_force_core_defines.svh"

module u1pg_core_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_command,
   input logic rsp_valid
);

   // a result word lasts one cycle
   `U1PG_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)

   // results appear only once the engine is back to idle
   `U1PG_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy)

   // a write word leaves busy low and makes no result
   `U1PG_ASSERT_NEXT(a_write_quick, start && !busy && !req_command, !busy && !rsp_valid)

   // a read word starts the sequence at once
   `U1PG_ASSERT_NEXT(a_read_busy, start && !busy && req_command, busy && !rsp_valid)

endmodule

bind u1_plaquette_gauge_force_core u1pg_core_checker u_checker (.*);
